### design/sti_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sti_pkg
// shared types, widths and elaboration-time rotor constants for the
// sine table interpolator
// ----------------------------------------------------------------------------
package sti_pkg;

  localparam int PHASE_W = 24;
  localparam int VALUE_W = 26;
  localparam int ROTOR_W = 32;
  localparam int Q30_SHIFT = 30;
  localparam int OUT_SHIFT = 6;
  localparam int TAYLOR_TERMS = 12;

  localparam logic [63:0] TWO_PI_Q60 = 64'h6487_ED51_10B4_611A;
  localparam logic [63:0] Q60_ONE = 64'h1000_0000_0000_0000;
  localparam logic [63:0] HALF_Q30_U = 64'h0000_0000_2000_0000;
  localparam logic signed [63:0] HALF_Q30 = 64'sh0000_0000_2000_0000;
  localparam logic signed [ROTOR_W-1:0] ROTOR_ONE = 32'sh4000_0000;
  localparam logic signed [ROTOR_W:0] OUT_ROUND = 33'sd32;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic signed [VALUE_W-1:0] delta;
  } entry_t;

  // truncating unsigned quotient by shift and subtract, elaboration only
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // rounded q30 cos or sin of 2*pi / 2^lg by taylor series in q60
  function automatic logic [ROTOR_W-1:0] rotor_const(input int lg, input bit want_sin);
    logic [127:0] wide;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] ct;
    logic [63:0] st;
    logic [63:0] csum;
    logic [63:0] ssum;
    logic [63:0] den_c;
    logic [63:0] den_s;
    logic [63:0] res;
    x = TWO_PI_Q60 >> lg;
    wide = {64'd0, x} * {64'd0, x};
    x2 = wide[123:60];
    ct = Q60_ONE;
    csum = Q60_ONE;
    st = x;
    ssum = x;
    for (int k = 1; k <= TAYLOR_TERMS; k++) begin
      den_c = 64'((2 * k - 1) * (2 * k));
      den_s = 64'((2 * k) * (2 * k + 1));
      wide = {64'd0, ct} * {64'd0, x2};
      ct = udiv64(wide[123:60], den_c);
      wide = {64'd0, st} * {64'd0, x2};
      st = udiv64(wide[123:60], den_s);
      if (k[0]) begin
        csum = csum - ct;
        ssum = ssum - st;
      end else begin
        csum = csum + ct;
        ssum = ssum + st;
      end
    end
    res = (want_sin ? ssum : csum) + HALF_Q30_U;
    return res[61:30];
  endfunction

endpackage
`default_nettype wire

### design/sti_builder.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sti_builder
// after reset steps a q30 rotation recurrence through one shared multiplier
// and writes value / delta entries, first half and negated mirror half
// ----------------------------------------------------------------------------
module sti_builder #(
  parameter int LOG2_SAMPLES = 10
) (
  input  wire                       clk,
  input  wire                       rst,
  output logic                      wr_en,
  output logic [LOG2_SAMPLES-1:0]   wr_addr,
  output sti_pkg::entry_t           wr_data,
  output logic                      done
);
  import sti_pkg::*;

  localparam int HALF_W = LOG2_SAMPLES - 1;
  localparam logic signed [ROTOR_W-1:0] ROT_C = rotor_const(LOG2_SAMPLES, 1'b0);
  localparam logic signed [ROTOR_W-1:0] ROT_S = rotor_const(LOG2_SAMPLES, 1'b1);

  typedef enum logic [2:0] {
    S_MUL0, S_MUL1, S_MUL2, S_MUL3, S_MUL4, S_LAST0, S_LAST1, S_DONE
  } state_t;

  state_t                     state;
  logic signed [ROTOR_W-1:0]  rcos;
  logic signed [ROTOR_W-1:0]  rsin;
  logic signed [ROTOR_W-1:0]  nsin;
  logic signed [63:0]         prod;
  logic signed [63:0]         acc;
  logic [HALF_W-1:0]          idx;
  logic signed [VALUE_W-1:0]  y_prev;
  logic signed [VALUE_W-1:0]  y_first;

  logic signed [ROTOR_W-1:0]  mul_a;
  logic signed [ROTOR_W-1:0]  mul_b;
  logic signed [63:0]         prod_next;
  logic signed [63:0]         sin_sum;
  logic signed [63:0]         cos_sum;
  logic signed [ROTOR_W:0]    sin_round;
  logic signed [VALUE_W-1:0]  y_cur;
  logic [HALF_W-1:0]          idx_prev;

  always_comb begin
    case (state)
      S_MUL0:  begin mul_a = rcos; mul_b = ROT_S; end
      S_MUL1:  begin mul_a = rsin; mul_b = ROT_C; end
      S_MUL2:  begin mul_a = rcos; mul_b = ROT_C; end
      S_MUL3:  begin mul_a = rsin; mul_b = ROT_S; end
      default: begin mul_a = '0;   mul_b = '0;    end
    endcase
  end

  assign prod_next = mul_a * mul_b;
  assign sin_sum = acc + prod;
  assign cos_sum = acc - prod;
  assign sin_round = {rsin[ROTOR_W-1], rsin} + OUT_ROUND;
  assign y_cur = sin_round[OUT_SHIFT +: VALUE_W];
  assign idx_prev = idx - HALF_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_MUL0;
      rcos    <= ROTOR_ONE;
      rsin    <= '0;
      nsin    <= '0;
      prod    <= '0;
      acc     <= '0;
      idx     <= '0;
      y_prev  <= '0;
      y_first <= '0;
      wr_en   <= 1'b0;
      wr_addr <= '0;
      wr_data <= '0;
      done    <= 1'b0;
    end else begin
      wr_en <= 1'b0;
      unique case (state)
        S_MUL0: begin
          prod          <= prod_next;
          wr_en         <= (idx != '0);
          wr_addr       <= {1'b0, idx_prev};
          wr_data.value <= y_prev;
          wr_data.delta <= y_cur - y_prev;
          state         <= S_MUL1;
        end
        S_MUL1: begin
          prod          <= prod_next;
          acc           <= prod + HALF_Q30;
          wr_en         <= (idx != '0);
          wr_addr       <= {1'b1, idx_prev};
          wr_data.value <= -y_prev;
          wr_data.delta <= y_prev - y_cur;
          state         <= S_MUL2;
        end
        S_MUL2: begin
          prod  <= prod_next;
          nsin  <= sin_sum[Q30_SHIFT +: ROTOR_W];
          state <= S_MUL3;
        end
        S_MUL3: begin
          prod  <= prod_next;
          acc   <= prod + HALF_Q30;
          state <= S_MUL4;
        end
        S_MUL4: begin
          rcos   <= cos_sum[Q30_SHIFT +: ROTOR_W];
          rsin   <= nsin;
          y_prev <= y_cur;
          if (idx == '0) begin
            y_first <= y_cur;
          end
          idx <= idx + HALF_W'(1);
          if (idx == '1) begin
            state <= S_LAST0;
          end else begin
            state <= S_MUL0;
          end
        end
        S_LAST0: begin
          wr_en         <= 1'b1;
          wr_addr       <= {1'b0, {HALF_W{1'b1}}};
          wr_data.value <= y_prev;
          wr_data.delta <= -y_first - y_prev;
          state         <= S_LAST1;
        end
        S_LAST1: begin
          wr_en         <= 1'b1;
          wr_addr       <= {1'b1, {HALF_W{1'b1}}};
          wr_data.value <= -y_prev;
          wr_data.delta <= y_first + y_prev;
          state         <= S_DONE;
        end
        S_DONE: begin
          done <= 1'b1;
        end
      endcase
    end
  end

  a_done_sticky: assert property (@(posedge clk) disable iff (rst)
    done |=> done) else $error("table ready dropped");
  a_no_write_when_done: assert property (@(posedge clk) disable iff (rst)
    done |-> !wr_en) else $error("table write after build finished");
  a_mirror_follows: assert property (@(posedge clk) disable iff (rst)
    wr_en && !wr_addr[HALF_W] |=> wr_en && wr_addr[HALF_W])
    else $error("mirror write missing");

endmodule
`default_nettype wire

### design/sti_readout.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sti_readout
// three stage read path: table read, delta times fraction, add and output
// ----------------------------------------------------------------------------
module sti_readout #(
  parameter int LOG2_SAMPLES = 10
) (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               ready,
  input  wire                               wr_en,
  input  wire [LOG2_SAMPLES-1:0]            wr_addr,
  input  sti_pkg::entry_t                   wr_data,
  input  wire                               in_valid,
  output logic                              in_stall,
  input  wire [sti_pkg::PHASE_W-1:0]        phase,
  output logic                              out_valid,
  input  wire                               out_stall,
  output logic signed [sti_pkg::VALUE_W-1:0] sine_value
);
  import sti_pkg::*;

  localparam int DEPTH = 1 << LOG2_SAMPLES;
  localparam int FRAC = PHASE_W - LOG2_SAMPLES;

  entry_t                      mem [DEPTH];
  entry_t                      rd;
  logic                        v1;
  logic                        v2;
  logic [FRAC-1:0]             lo1;
  logic signed [VALUE_W-1:0]   val2;
  logic signed [VALUE_W+FRAC:0] prod2;
  logic                        en;
  logic [LOG2_SAMPLES-1:0]     rd_addr;

  assign en = !out_valid || !out_stall;
  assign in_stall = !ready || !en;
  assign rd_addr = phase[PHASE_W-1 -: LOG2_SAMPLES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (en) begin
      rd <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lo1        <= phase[FRAC-1:0];
      val2       <= rd.value;
      prod2      <= rd.delta * signed'({1'b0, lo1});
      sine_value <= val2 + prod2[FRAC +: VALUE_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid && ready;
      v2        <= v1;
      out_valid <= v2;
    end
  end

  a_empty_during_build: assert property (@(posedge clk) disable iff (rst)
    !ready |-> !v1 && !v2 && !out_valid) else $error("item in flight during build");
  a_stage_advance: assert property (@(posedge clk) disable iff (rst)
    v2 && en |=> out_valid) else $error("transaction lost between stages");
  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(v1) && $stable(v2)) else $error("pipeline moved while stalled");

endmodule
`default_nettype wire

### design/sine_table_interpolator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sine_table_interpolator
// q24 sine oscillator read-out from a table with linear interpolation
//
//   channel | signals                        | direction | payload
//   in      | in_valid, in_stall, phase      | input     | 24-bit phase
//   out     | out_valid, out_stall, sine_value| output   | 26-bit signed q24
//
// one transaction per cycle while neither stall holds it; the input passes the
// table read and multiply registers into the output register. after reset the
// table build steps the shared rotor multiplier through S_MUL0 to S_MUL4 per entry pair;
// in_stall stays high until the build ends
// out_stall freezes all three stages while out_valid is high, in_stall follows it the same cycle
// ----------------------------------------------------------------------------
module sine_table_interpolator #(
  parameter int LOG2_SAMPLES = 10
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                in_valid,
  output logic                               in_stall,
  input  wire [sti_pkg::PHASE_W-1:0]         phase,
  output logic                               out_valid,
  input  wire                                out_stall,
  output logic signed [sti_pkg::VALUE_W-1:0] sine_value
);
  import sti_pkg::*;

  logic                    wr_en;
  logic [LOG2_SAMPLES-1:0] wr_addr;
  entry_t                  wr_data;
  logic                    table_ready;

  sti_builder #(
    .LOG2_SAMPLES(LOG2_SAMPLES)
  ) u_builder (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .done    (table_ready)
  );

  sti_readout #(
    .LOG2_SAMPLES(LOG2_SAMPLES)
  ) u_readout (
    .clk        (clk),
    .rst        (rst),
    .ready      (table_ready),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .phase      (phase),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .sine_value (sine_value)
  );

endmodule
`default_nettype wire
